// File: src/hmlps_pkg.sv
// Shared constants and types for the heatmap peak suppressor.
package hmlps_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAX_KERNEL  = 7;
   localparam int SAMPLE_BITS = 16;

   localparam int WIN        = MAX_KERNEL;
   localparam int REACH_CAP  = (MAX_KERNEL - 1) / 2;
   localparam int REACH_BITS = (REACH_CAP > 0) ? $clog2(REACH_CAP + 1) : 1;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int SIZE_BITS  = 11;
   localparam int KSIZE_BITS = 3;
   localparam int DLY_BITS   = $clog2(REACH_CAP * MAX_WIDTH + REACH_CAP + 1);
   localparam int IDX_BITS   = 20;
   localparam int ADDR_BITS  = 5;

   localparam logic [ADDR_BITS-3:0] REG_KH  = 3'd0;
   localparam logic [ADDR_BITS-3:0] REG_KW  = 3'd1;
   localparam logic [ADDR_BITS-3:0] REG_THR = 3'd2;
   localparam logic [ADDR_BITS-3:0] REG_FH  = 3'd3;
   localparam logic [ADDR_BITS-3:0] REG_FW  = 3'd4;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] smp_type;
   localparam smp_type MIN_CODE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef smp_type tap_row_type [WIN];
   typedef tap_row_type window_type [WIN];

   typedef struct packed {
      logic    opcode;
      smp_type sample;
   } req_word_type;

   typedef struct packed {
      smp_type               kept_value;
      logic                  is_peak;
      logic [IDX_BITS-1:0]   peak_index;
      logic                  last_in_frame;
   } rsp_word_type;

   typedef struct packed {
      logic                  push;
      logic                  restart;
      logic [COL_BITS-1:0]   len;
   } cell_ctl_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0]  h;
      logic [SIZE_BITS-1:0]  w;
      logic [REACH_BITS-1:0] rh;
      logic [REACH_BITS-1:0] rw;
      logic [REACH_BITS-1:0] rhp;
      logic [REACH_BITS-1:0] rwp;
      smp_type               thr;
      logic [DLY_BITS-1:0]   dly;
   } geo_type;

endpackage

// File: src/hmlps_req_if.sv
// Request and response channel interfaces.
interface hmlps_req_if import hmlps_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hmlps_rsp_if import hmlps_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/hmlps_cell.sv
// One window row: line delay memory plus horizontal tap shift register.
module hmlps_cell import hmlps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  smp_type      din,
   output tap_row_type  taps
);

   smp_type              mem [MAX_WIDTH];
   smp_type              tap_ff [WIN];
   logic [COL_BITS-1:0]  ptr_ff;
   logic [COL_BITS-1:0]  ptr_in;
   logic [COL_BITS-1:0]  ptr_cur;

   assign ptr_cur = ctl.restart ? '0 : ptr_ff;

   always_comb begin
      ptr_in = ptr_ff;
      if (ctl.push) begin
         if (ctl.len == '0 || ptr_cur == ctl.len - 1'b1) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_cur + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   // read-first ring: the read returns the word written len pushes ago
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         if (ctl.len == '0) begin
            tap_ff[0] <= din;
         end else begin
            tap_ff[0]    <= mem[ptr_cur];
            mem[ptr_cur] <= din;
         end
         for (int i = 1; i < WIN; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign taps = tap_ff;

endmodule

// File: src/hmlps_judge.sv
// Window compare: decides whether the centre is the first maximum of its window.
module hmlps_judge import hmlps_pkg::*; (
   input  window_type          win,
   input  geo_type             geo,
   input  logic [ROW_BITS-1:0] row,
   input  logic [COL_BITS-1:0] col,
   output smp_type             kept,
   output logic                peak
);

   logic [WIN-1:0] row_ok;
   logic [WIN-1:0] col_ok;
   smp_type        centre;
   logic           ok;

   assign centre = win[geo.rhp][geo.rwp];

   always_comb begin
      int  dri;
      int  dci;
      logic earlier;
      ok = 1'b1;
      for (int j = 0; j < WIN; j++) begin
         dri = int'(geo.rhp) - j;
         row_ok[j] = (dri <= int'(geo.rh)) && (-dri <= int'(geo.rh)) &&
                     (int'(row) + dri >= 0) && (int'(row) + dri < int'(geo.h));
      end
      for (int i = 0; i < WIN; i++) begin
         dci = int'(geo.rwp) - i;
         col_ok[i] = (dci <= int'(geo.rw)) && (-dci <= int'(geo.rw)) &&
                     (int'(col) + dci >= 0) && (int'(col) + dci < int'(geo.w));
      end
      // grid row j / column i sits rhp-j rows and rwp-i columns from the centre
      for (int j = 0; j < WIN; j++) begin
         for (int i = 0; i < WIN; i++) begin
            earlier = (j > int'(geo.rhp)) || (j == int'(geo.rhp) && i > int'(geo.rwp));
            if (row_ok[j] && col_ok[i]) begin
               if (earlier ? (win[j][i] >= centre) : (win[j][i] > centre)) begin
                  ok = 1'b0;
               end
            end
         end
      end
   end

   assign peak = ok && (centre != MIN_CODE) && (centre >= geo.thr);
   assign kept = peak ? centre : MIN_CODE;

endmodule

// File: src/heatmap_local_peak_suppress.sv
// Top level: streaming 2-D local peak suppression over a raster heatmap.
//
// req_ch carries words {opcode, sample}; opcode 0 is a pixel, 1 a drain tick.
// rsp_ch carries one word per pixel {kept_value, is_peak, peak_index,
// last_in_frame}, in raster order. Geometry and threshold are written over
// the APB port (psel/penable/pwrite/paddr/pwdata) and latched when the first
// pixel of a frame arrives.
// Throughput: one word per clock while rsp_ch does not stall, set by the row
// of window cells that each take one line-memory access per word.
// The result of pixel k is produced by input word k+D of the frame
// (D = rh'*W + rw', the window reach after clipping). The window shifts when
// that word is taken, the compare stage holds the pixel while it is judged,
// and the compare result is registered in the output register, which drives
// rsp_ch. After the last pixel, D drain words flush the rest.
// Reset clears all frame counters and flags; line memories are not cleared,
// since clipping keeps words of earlier frames out of every window.
// When rsp_ch stalls, one result waits in the output register and one in the
// compare stage; req_ch.ready drops only when both are held.
module heatmap_local_peak_suppress import hmlps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   hmlps_req_if.sink            req_ch,
   hmlps_rsp_if.source          rsp_ch,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   // ---------------- configuration registers
   logic [KSIZE_BITS-1:0] kh_ff, kw_ff;
   smp_type               thr_ff;
   logic [SIZE_BITS-1:0]  fh_ff, fw_ff;
   logic                  wr_en;
   logic [ADDR_BITS-3:0]  reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         kh_ff  <= KSIZE_BITS'(3);
         kw_ff  <= KSIZE_BITS'(3);
         thr_ff <= '0;
         fh_ff  <= SIZE_BITS'(MAX_HEIGHT);
         fw_ff  <= SIZE_BITS'(MAX_WIDTH);
      end else if (wr_en) begin
         case (reg_sel)
            REG_KH:  kh_ff  <= pwdata[KSIZE_BITS-1:0];
            REG_KW:  kw_ff  <= pwdata[KSIZE_BITS-1:0];
            REG_THR: thr_ff <= pwdata[SAMPLE_BITS-1:0];
            REG_FH:  fh_ff  <= pwdata[SIZE_BITS-1:0];
            REG_FW:  fw_ff  <= pwdata[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_KH:  prdata = 32'(kh_ff);
         REG_KW:  prdata = 32'(kw_ff);
         REG_THR: prdata = 32'({16'(0), thr_ff});
         REG_FH:  prdata = 32'(fh_ff);
         REG_FW:  prdata = 32'(fw_ff);
         default: prdata = '0;
      endcase
   end

   // ---------------- frame geometry, taken at frame start
   geo_type geo_new, geo_ff, geo_cur;

   always_comb begin
      logic [KSIZE_BITS-1:0] hr, wr;
      geo_new = '0;
      if (fh_ff == '0) geo_new.h = SIZE_BITS'(1);
      else if (fh_ff > SIZE_BITS'(MAX_HEIGHT)) geo_new.h = SIZE_BITS'(MAX_HEIGHT);
      else geo_new.h = fh_ff;
      if (fw_ff == '0) geo_new.w = SIZE_BITS'(1);
      else if (fw_ff > SIZE_BITS'(MAX_WIDTH)) geo_new.w = SIZE_BITS'(MAX_WIDTH);
      else geo_new.w = fw_ff;
      hr = kh_ff >> 1;
      wr = kw_ff >> 1;
      geo_new.rh  = (hr > KSIZE_BITS'(REACH_CAP)) ? REACH_BITS'(REACH_CAP) : hr[REACH_BITS-1:0];
      geo_new.rw  = (wr > KSIZE_BITS'(REACH_CAP)) ? REACH_BITS'(REACH_CAP) : wr[REACH_BITS-1:0];
      geo_new.rhp = (SIZE_BITS'(geo_new.rh) > geo_new.h - 1'b1)
                    ? REACH_BITS'(geo_new.h - 1'b1) : geo_new.rh;
      geo_new.rwp = (SIZE_BITS'(geo_new.rw) > geo_new.w - 1'b1)
                    ? REACH_BITS'(geo_new.w - 1'b1) : geo_new.rw;
      geo_new.thr = thr_ff;
      geo_new.dly = DLY_BITS'(geo_new.rhp) * DLY_BITS'(geo_new.w) + DLY_BITS'(geo_new.rwp);
   end

   // ---------------- frame control
   logic                  active_ff, done_ff;
   logic [ROW_BITS-1:0]   in_row_ff, out_row_ff;
   logic [COL_BITS-1:0]   in_col_ff, out_col_ff;
   logic [DLY_BITS-1:0]   cnt_ff, cnt_cur;
   logic [IDX_BITS-1:0]   idx_ff;
   logic                  accept, is_smp, start, tick, emit, last, done_cur;

   // compare stage and output register
   logic                  pend_ff, pend_last_ff;
   logic [ROW_BITS-1:0]   pend_row_ff;
   logic [COL_BITS-1:0]   pend_col_ff;
   logic [IDX_BITS-1:0]   pend_idx_ff;
   logic                  rsp_valid_ff, move;
   rsp_word_type          rsp_ff;

   assign move         = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !pend_ff || move;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_smp       = (req_ch.payload.opcode == OP_SAMPLE);
   assign start        = is_smp && !active_ff;
   assign geo_cur      = start ? geo_new : geo_ff;
   assign done_cur     = start ? 1'b0 : done_ff;
   assign cnt_cur      = start ? '0 : cnt_ff;
   // a sample after the last pixel counts as a drain word
   assign tick         = is_smp || (active_ff && done_ff);
   assign emit         = (cnt_cur == geo_cur.dly);
   assign last         = (SIZE_BITS'(out_row_ff) == geo_cur.h - 1'b1) &&
                         (SIZE_BITS'(out_col_ff) == geo_cur.w - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_ff     <= '0;
         active_ff  <= 1'b0;
         done_ff    <= 1'b0;
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         cnt_ff     <= '0;
         idx_ff     <= '0;
      end else if (accept && tick) begin
         geo_ff    <= geo_cur;
         active_ff <= 1'b1;
         done_ff   <= done_cur;
         cnt_ff    <= emit ? cnt_cur : cnt_cur + 1'b1;
         if (is_smp && !done_cur) begin
            if (SIZE_BITS'(in_col_ff) == geo_cur.w - 1'b1) begin
               in_col_ff <= '0;
               if (SIZE_BITS'(in_row_ff) == geo_cur.h - 1'b1) begin
                  in_row_ff <= '0;
                  done_ff   <= 1'b1;
               end else begin
                  in_row_ff <= in_row_ff + 1'b1;
               end
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end
         if (emit) begin
            if (last) begin
               active_ff  <= 1'b0;
               done_ff    <= 1'b0;
               in_row_ff  <= '0;
               in_col_ff  <= '0;
               out_row_ff <= '0;
               out_col_ff <= '0;
               cnt_ff     <= '0;
               idx_ff     <= '0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
               if (SIZE_BITS'(out_col_ff) == geo_cur.w - 1'b1) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + 1'b1;
               end else begin
                  out_col_ff <= out_col_ff + 1'b1;
               end
            end
         end
      end
   end

   // ---------------- chain of window rows
   window_type   win;
   cell_ctl_type ctl_row, ctl_head;

   assign ctl_head.push    = accept && tick;
   assign ctl_head.restart = start;
   assign ctl_head.len     = '0;
   assign ctl_row.push     = accept && tick;
   assign ctl_row.restart  = start;
   assign ctl_row.len      = COL_BITS'(geo_cur.w - 1'b1);

   hmlps_cell u_cell_head (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl_head),
      .din   (req_ch.payload.sample),
      .taps  (win[0])
   );

   for (genvar g = 1; g < WIN; g++) begin : g_cell
      hmlps_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl_row),
         .din   (win[g-1][0]),
         .taps  (win[g])
      );
   end

   // ---------------- compare and output
   smp_type kept;
   logic    peak;

   hmlps_judge u_judge (
      .win  (win),
      .geo  (geo_ff),
      .row  (pend_row_ff),
      .col  (pend_col_ff),
      .kept (kept),
      .peak (peak)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept && tick && emit) pend_ff <= 1'b1;
         else if (move) pend_ff <= 1'b0;
         if (move) rsp_valid_ff <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && tick && emit) begin
         pend_row_ff  <= out_row_ff;
         pend_col_ff  <= out_col_ff;
         pend_idx_ff  <= idx_ff;
         pend_last_ff <= last;
      end
      if (move && pend_ff) begin
         rsp_ff.kept_value    <= kept;
         rsp_ff.is_peak       <= peak;
         rsp_ff.peak_index    <= pend_idx_ff;
         rsp_ff.last_in_frame <= pend_last_ff;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   // ---------------- checks
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !move) |-> !req_ch.ready)
      else $error("input taken while compare stage is held");

   a_peak_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.is_peak) |-> (rsp_ch.payload.kept_value != MIN_CODE))
      else $error("peak carries the most negative code");

   a_nonpeak_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.payload.is_peak) |-> (rsp_ch.payload.kept_value == MIN_CODE))
      else $error("suppressed pixel keeps its value");

endmodule
